// ===== rtl/core/saturating_direction_range_binner_assert.svh =====
// Assertion macros shared by the binner RTL.
`ifndef SATURATING_DIRECTION_RANGE_BINNER_ASSERT_SVH
`define SATURATING_DIRECTION_RANGE_BINNER_ASSERT_SVH

`define SDRB_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication check failed");

`define SDRB_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/sdrb_pkg.sv =====
`default_nettype none
package sdrb_pkg;

  localparam int DEF_MAX_XY_DIRS     = 8;
  localparam int DEF_MAX_AZ_DIVS     = 16;
  localparam int DEF_NUM_RANGE_DIVS  = 3;
  localparam int DEF_COUNT_WIDTH     = 8;
  localparam int DEF_ANGLE_FRAC_BITS = 16;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CORDIC_XW    = 23;
  localparam int ACC_W        = 34;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam int REG_Z_CUTOFF  = 0;
  localparam int REG_XY_DIRS   = 1;
  localparam int REG_AZ_DIVS   = 2;
  localparam int REG_Z_LIMIT   = 3;
  localparam int REG_XY_LIMIT  = 4;
  localparam int REG_RANGE_DIV = 5;

  localparam logic signed [15:0] RST_Z_CUTOFF = 16'sd14189;
  localparam logic [3:0]  RST_XY_DIRS  = 4'd4;
  localparam logic [4:0]  RST_AZ_DIVS  = 5'd8;
  localparam logic [7:0]  RST_LIMIT    = 8'd10;
  localparam logic [19:0] THR_UNUSED   = 20'hFFFFF;

  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      4'd0:    v = 32'h20000000;
      4'd1:    v = 32'h12E4051E;
      4'd2:    v = 32'h09FB385B;
      4'd3:    v = 32'h051111D4;
      4'd4:    v = 32'h028B0D43;
      4'd5:    v = 32'h0145D7E1;
      4'd6:    v = 32'h00A2F61E;
      4'd7:    v = 32'h00517C55;
      4'd8:    v = 32'h0028BE53;
      4'd9:    v = 32'h00145F2F;
      4'd10:   v = 32'h000A2F98;
      4'd11:   v = 32'h000517CC;
      4'd12:   v = 32'h00028BE6;
      4'd13:   v = 32'h000145F3;
      4'd14:   v = 32'h0000A2FA;
      4'd15:   v = 32'h0000517D;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sdrb_cordic.sv =====
`default_nettype none
module sdrb_cordic
  import sdrb_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic signed [CORDIC_XW-1:0] x_in,
  input  wire logic signed [CORDIC_XW-1:0] y_in,
  output logic                             done,
  output logic [ANGLE_FRAC_BITS-1:0]       frac
);

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd2147483648);
  localparam logic signed [ACC_W-1:0] FULL = ACC_W'(64'sd4294967295);

  logic                        run_r, done_r;
  logic [STEP_W-1:0]           step_r;
  logic signed [CORDIC_XW-1:0] x_r, y_r, dx, dy;
  logic signed [ACC_W-1:0]     acc_r, ang, turn;
  logic [31:0]                 sat;

  assign dx  = y_r >>> step_r;
  assign dy  = x_r >>> step_r;
  assign ang = $signed({2'b00, atan_turn(step_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= start ? (x_in == '0 && y_in == '0)
                      : (run_r && step_r == STEP_W'(CORDIC_STEPS - 1));
      if (start) begin
        step_r <= '0;
        if (x_in == '0 && y_in == '0) begin
          acc_r <= '0;
        end else begin
          run_r <= 1'b1;
          if (x_in < 0) begin
            acc_r <= (y_in >= 0) ? HALF : -HALF;
            x_r   <= -x_in;
            y_r   <= -y_in;
          end else begin
            acc_r <= '0;
            x_r   <= x_in;
            y_r   <= y_in;
          end
        end
      end else if (run_r) begin
        if (y_r > 0) begin
          x_r   <= x_r + dx;
          y_r   <= y_r - dy;
          acc_r <= acc_r + ang;
        end else begin
          x_r   <= x_r - dx;
          y_r   <= y_r + dy;
          acc_r <= acc_r - ang;
        end
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    turn = acc_r + HALF;
    if (turn < 0) begin
      sat = '0;
    end else if (turn > FULL) begin
      sat = '1;
    end else begin
      sat = turn[31:0];
    end
  end

  assign done = done_r;
  assign frac = sat[31 -: ANGLE_FRAC_BITS];

endmodule
`default_nettype wire

// ===== rtl/core/saturating_direction_range_binner.sv =====
// Direction and range binner with saturating per-bin counters.
// Input channel (in_valid/in_ready) carries one beat per item: a command, a
// unit direction and a point. The result channel (out_valid/out_ready)
// returns one beat per item: ok, the bin count after the command and the
// three bin indices. The configuration port writes one register per cycle
// with cfg_we; every write to a defined register also clears all bins.
// A result is valid after two passes of the single shared CORDIC unit
// (direction, then point azimuth), a counter read and an update; a pass over
// a zero vector skips the iterations. The range squares run on one
// multiplier during the first pass; the counter read never starts before
// they are done. Then ST_RD reads and ST_UPD updates the counter memory.
// in_ready is high only while the sequencer is idle, so a new item is
// accepted only once the previous one has left ST_UPD. A clear command, a
// register write and reset start a sweep that zeroes the counter store, one
// entry a cycle (576 entries at the default sizes); no item is accepted
// during the sweep. A result sits in the output register until taken; if
// the receiver stalls, the next item finishes its work and waits before
// its update.
`default_nettype none
module saturating_direction_range_binner
  import sdrb_pkg::*;
#(
  parameter int MAX_XY_DIRS     = DEF_MAX_XY_DIRS,
  parameter int MAX_AZ_DIVS     = DEF_MAX_AZ_DIVS,
  parameter int NUM_RANGE_DIVS  = DEF_NUM_RANGE_DIVS,
  parameter int COUNT_WIDTH     = DEF_COUNT_WIDTH,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  localparam int DIR_W = $clog2(MAX_XY_DIRS + 1),
  localparam int AZ_W  = (MAX_AZ_DIVS > 1) ? $clog2(MAX_AZ_DIVS) : 1,
  localparam int RNG_W = $clog2(NUM_RANGE_DIVS + 1),
  localparam int CFG_W = $clog2(REG_RANGE_DIV + NUM_RANGE_DIVS)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_W-1:0]        cfg_addr,
  input  wire logic [19:0]             cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_cmd,
  input  wire logic signed [15:0]      in_dir_x,
  input  wire logic signed [15:0]      in_dir_y,
  input  wire logic signed [15:0]      in_dir_z,
  input  wire logic signed [19:0]      in_pt_x,
  input  wire logic signed [19:0]      in_pt_y,
  input  wire logic signed [19:0]      in_pt_z,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_ok,
  output logic [COUNT_WIDTH-1:0]       out_count,
  output logic [DIR_W-1:0]             out_dir_index,
  output logic [AZ_W-1:0]              out_azimuth_index,
  output logic [RNG_W-1:0]             out_range_index
);

  localparam int RNG_BINS   = NUM_RANGE_DIVS + 1;
  localparam int DEPTH      = (MAX_XY_DIRS + 1) * MAX_AZ_DIVS * RNG_BINS;
  localparam int AW         = $clog2(DEPTH);
  localparam int COUNT_MAX  = (1 << COUNT_WIDTH) - 1;
  localparam int NXY_W      = $clog2(MAX_XY_DIRS + 1);
  localparam int NAZ_W      = $clog2(MAX_AZ_DIVS + 1);
  localparam int NW         = (NXY_W > NAZ_W) ? NXY_W : NAZ_W;
  localparam int SQ_ITEMS   = 3 + NUM_RANGE_DIVS;
  localparam int SQ_W       = $clog2(SQ_ITEMS + 1);
  localparam int THR_W      = (NUM_RANGE_DIVS > 1) ? $clog2(NUM_RANGE_DIVS) : 1;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIR  = 3'd2;
  localparam logic [2:0] ST_AZ   = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;

  logic [2:0] state_r;
  logic [AW-1:0] clr_cnt_r;

  logic signed [15:0] z_cut_r;
  logic [3:0]  xy_dirs_r;
  logic [4:0]  az_divs_r;
  logic [7:0]  z_lim_r, xy_lim_r;
  logic [19:0] thr_r [NUM_RANGE_DIVS];

  logic [1:0]         cmd_r;
  logic signed [15:0] dz_r;
  logic signed [19:0] px_r, py_r;
  logic [19:0]        ax_r, ay_r, az_abs_r;

  logic [SQ_W-1:0]  sq_cnt_r;
  logic             sq_run_r;
  logic [19:0]      sq_op;
  logic [39:0]      prod_r, norm_r;
  logic [RNG_W-1:0] rng_r;
  logic [THR_W-1:0] thr_idx;

  logic [DIR_W-1:0] dir_sec_r, dir_idx_r, dir_sel;
  logic [AZ_W-1:0]  az_idx_r;
  logic [AW-1:0]    addr_r, addr_nxt;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data_r, new_cnt, lim;
  logic                   new_ok, upd_we, out_free, cfg_hit;
  logic                   out_valid_r, out_ok_r;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic [DIR_W-1:0]       out_dir_r;
  logic [AZ_W-1:0]        out_az_r;
  logic [RNG_W-1:0]       out_rng_r;

  logic                              c_start, c_done;
  logic signed [CORDIC_XW-1:0]       c_x, c_y;
  logic [ANGLE_FRAC_BITS-1:0]        c_frac;
  logic [NW-1:0]                     n_sel, sec;
  logic [ANGLE_FRAC_BITS+NW-1:0]     sec_prod;
  logic [7:0]                        lim8;

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign cfg_hit  = cfg_we && (32'(cfg_addr) < REG_RANGE_DIV + NUM_RANGE_DIVS);

  always_comb begin
    if (state_r == ST_IDLE) begin
      c_start = in_valid;
      c_x     = CORDIC_XW'(in_dir_x);
      c_y     = CORDIC_XW'(in_dir_y);
    end else begin
      c_start = (state_r == ST_DIR) && c_done;
      c_x     = CORDIC_XW'(px_r);
      c_y     = CORDIC_XW'(py_r);
    end
  end

  sdrb_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (c_start),
    .x_in  (c_x),
    .y_in  (c_y),
    .done  (c_done),
    .frac  (c_frac)
  );

  always_comb begin
    if (state_r == ST_DIR) begin
      if (xy_dirs_r == '0) begin
        n_sel = NW'(1);
      end else if (32'(xy_dirs_r) > MAX_XY_DIRS) begin
        n_sel = NW'(MAX_XY_DIRS);
      end else begin
        n_sel = NW'(xy_dirs_r);
      end
    end else begin
      if (az_divs_r == '0) begin
        n_sel = NW'(1);
      end else if (32'(az_divs_r) > MAX_AZ_DIVS) begin
        n_sel = NW'(MAX_AZ_DIVS);
      end else begin
        n_sel = NW'(az_divs_r);
      end
    end
    sec_prod = (ANGLE_FRAC_BITS + NW)'(c_frac) * (ANGLE_FRAC_BITS + NW)'(n_sel);
    sec      = NW'(sec_prod >> ANGLE_FRAC_BITS);
    if (sec > n_sel - 1'b1) begin
      sec = n_sel - 1'b1;
    end
  end

  assign thr_idx = THR_W'(sq_cnt_r - SQ_W'(3));

  always_comb begin
    case (sq_cnt_r)
      SQ_W'(0): sq_op = ax_r;
      SQ_W'(1): sq_op = ay_r;
      SQ_W'(2): sq_op = az_abs_r;
      default:  sq_op = thr_r[thr_idx];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_run_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      sq_run_r <= 1'b1;
      sq_cnt_r <= '0;
      norm_r   <= '0;
      rng_r    <= '0;
    end else if (sq_run_r) begin
      if (sq_cnt_r < SQ_W'(SQ_ITEMS)) begin
        prod_r <= 40'(sq_op) * 40'(sq_op);
      end
      if (sq_cnt_r >= SQ_W'(1) && sq_cnt_r <= SQ_W'(3)) begin
        norm_r <= norm_r + prod_r;
      end else if (sq_cnt_r > SQ_W'(3) && prod_r <= norm_r) begin
        rng_r <= rng_r + 1'b1;
      end
      sq_cnt_r <= sq_cnt_r + 1'b1;
      if (sq_cnt_r == SQ_W'(SQ_ITEMS)) begin
        sq_run_r <= 1'b0;
      end
    end
  end

  always_comb begin
    dir_sel  = (dz_r > z_cut_r) ? '0 : dir_sec_r;
    addr_nxt = AW'((32'(dir_sel) * MAX_AZ_DIVS + 32'(az_idx_r)) * RNG_BINS
                   + 32'(rng_r));
    lim8     = (dir_idx_r == '0) ? z_lim_r : xy_lim_r;
    lim      = (32'(lim8) > COUNT_MAX) ? COUNT_WIDTH'(COUNT_MAX) : COUNT_WIDTH'(lim8);
    new_ok   = 1'b1;
    new_cnt  = rd_data_r;
    upd_we   = 1'b0;
    case (cmd_r)
      CMD_INSERT: begin
        upd_we = 1'b1;
        if (rd_data_r < lim) begin
          new_cnt = rd_data_r + 1'b1;
        end else begin
          new_ok = 1'b0;
        end
      end
      CMD_QUERY: begin
        new_ok = (rd_data_r < lim);
      end
      CMD_REMOVE: begin
        upd_we = 1'b1;
        if (rd_data_r != '0) begin
          new_cnt = rd_data_r - 1'b1;
        end
      end
      default: begin
        new_cnt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLR) begin
      mem[clr_cnt_r] <= '0;
    end else if (state_r == ST_UPD && out_free && upd_we) begin
      mem[addr_r] <= new_cnt;
    end
    if (state_r == ST_RD) begin
      rd_data_r <= mem[addr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_cut_r   <= RST_Z_CUTOFF;
      xy_dirs_r <= RST_XY_DIRS;
      az_divs_r <= RST_AZ_DIVS;
      z_lim_r   <= RST_LIMIT;
      xy_lim_r  <= RST_LIMIT;
      for (int i = 0; i < NUM_RANGE_DIVS; i++) begin
        thr_r[i] <= THR_UNUSED;
      end
    end else if (cfg_we) begin
      case (32'(cfg_addr))
        REG_Z_CUTOFF: z_cut_r   <= cfg_wdata[15:0];
        REG_XY_DIRS:  xy_dirs_r <= cfg_wdata[3:0];
        REG_AZ_DIVS:  az_divs_r <= cfg_wdata[4:0];
        REG_Z_LIMIT:  z_lim_r   <= cfg_wdata[7:0];
        REG_XY_LIMIT: xy_lim_r  <= cfg_wdata[7:0];
        default: begin
          for (int i = 0; i < NUM_RANGE_DIVS; i++) begin
            if (32'(cfg_addr) == REG_RANGE_DIV + i) begin
              thr_r[i] <= cfg_wdata;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_UPD && out_free && !cfg_hit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_hit) begin
        clr_cnt_r <= '0;
        state_r   <= ST_CLR;
      end else begin
        case (state_r)
          ST_CLR: begin
            clr_cnt_r <= clr_cnt_r + 1'b1;
            if (clr_cnt_r == AW'(DEPTH - 1)) begin
              state_r <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (in_valid) begin
              cmd_r    <= in_cmd;
              dz_r     <= in_dir_z;
              px_r     <= in_pt_x;
              py_r     <= in_pt_y;
              ax_r     <= in_pt_x[19] ? 20'(-in_pt_x) : 20'(in_pt_x);
              ay_r     <= in_pt_y[19] ? 20'(-in_pt_y) : 20'(in_pt_y);
              az_abs_r <= in_pt_z[19] ? 20'(-in_pt_z) : 20'(in_pt_z);
              state_r  <= ST_DIR;
            end
          end
          ST_DIR: begin
            if (c_done) begin
              dir_sec_r <= DIR_W'(sec) + 1'b1;
              state_r   <= ST_AZ;
            end
          end
          ST_AZ: begin
            if (c_done) begin
              az_idx_r <= AZ_W'(sec);
              state_r  <= ST_RD;
            end
          end
          ST_RD: begin
            if (!sq_run_r) begin
              dir_idx_r <= dir_sel;
              addr_r    <= addr_nxt;
              state_r   <= ST_UPD;
            end
          end
          ST_UPD: begin
            if (out_free) begin
              out_ok_r    <= new_ok;
              out_count_r <= new_cnt;
              out_dir_r   <= dir_idx_r;
              out_az_r    <= az_idx_r;
              out_rng_r   <= rng_r;
              if (cmd_r == CMD_CLEAR) begin
                clr_cnt_r <= '0;
                state_r   <= ST_CLR;
              end else begin
                state_r <= ST_IDLE;
              end
            end
          end
          default: begin
            state_r <= ST_IDLE;
          end
        endcase
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_count         = out_count_r;
  assign out_dir_index     = out_dir_r;
  assign out_azimuth_index = out_az_r;
  assign out_range_index   = out_rng_r;

`include "saturating_direction_range_binner_assert.svh"

  `SDRB_ASSERT_IMPL(a_done_in_pass, c_done, state_r == ST_DIR || state_r == ST_AZ)
  `SDRB_ASSERT_IMPL(a_squares_done, state_r == ST_UPD, !sq_run_r)
  `SDRB_ASSERT_NEXT(a_clear_result,
                    state_r == ST_UPD && out_free && cmd_r == CMD_CLEAR && !cfg_hit,
                    state_r == ST_CLR && out_count == '0 && out_valid)
  `SDRB_ASSERT_IMPL(a_range_bound, 1'b1, 32'(rng_r) <= NUM_RANGE_DIVS)

endmodule
`default_nettype wire

// ===== tb/tb_saturating_direction_range_binner.sv =====
`default_nettype none
module tb_saturating_direction_range_binner;
  timeunit 1ns;
  timeprecision 1ps;
  import sdrb_pkg::*;

  localparam int NXY_MAX = 8;
  localparam int NAZ_MAX = 16;
  localparam int NRB = 4;
  localparam int BIN_DEPTH = (NXY_MAX + 1) * NAZ_MAX * NRB;
  localparam longint HALF = 64'sd2147483648;

  typedef struct packed {
    logic [1:0] cmd;
    logic signed [15:0] dx, dy, dz;
    logic signed [19:0] px, py, pz;
  } probe_t;

  typedef struct packed {
    logic ok;
    logic [7:0] count;
    logic [3:0] dir;
    logic [3:0] az;
    logic [1:0] rng;
  } bin_result_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_addr;
  logic [19:0] cfg_wdata;
  logic in_valid, in_ready;
  logic [1:0] in_cmd;
  logic signed [15:0] in_dir_x, in_dir_y, in_dir_z;
  logic signed [19:0] in_pt_x, in_pt_y, in_pt_z;
  logic out_valid, out_ready, out_ok;
  logic [7:0] out_count;
  logic [3:0] out_dir_index, out_azimuth_index;
  logic [1:0] out_range_index;

  saturating_direction_range_binner u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_pt_x(in_pt_x), .in_pt_y(in_pt_y), .in_pt_z(in_pt_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_ok(out_ok),
    .out_count(out_count), .out_dir_index(out_dir_index),
    .out_azimuth_index(out_azimuth_index), .out_range_index(out_range_index)
  );

  logic [31:0] atan_step [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

  logic [7:0] bin_store [BIN_DEPTH];
  logic signed [15:0] cutoff_q;
  logic [3:0] xy_dirs_q;
  logic [4:0] az_divs_q;
  logic [7:0] zlim_q, xylim_q;
  logic [19:0] rthr_q [3];

  probe_t pending_beats[$];
  bin_result_t expected_bins[$];
  int fail_count;
  bit calm;
  int gap_left;
  int stall_left;
  probe_t pool [8];

  function automatic logic [15:0] turn_frac(longint x, longint y);
    longint acc, ddx, ddy;
    acc = 0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        acc = (y >= 0) ? HALF : -HALF;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        ddx = y >>> i;
        ddy = x >>> i;
        if (y > 0) begin
          x += ddx; y -= ddy; acc += longint'(atan_step[i]);
        end else begin
          x -= ddx; y += ddy; acc -= longint'(atan_step[i]);
        end
      end
    end
    acc += HALF;
    if (acc < 0) acc = 0;
    if (acc > 64'sd4294967295) acc = 64'sd4294967295;
    return acc[31:16];
  endfunction

  function automatic int sector(logic [15:0] frac, int n);
    int s;
    s = int'((longint'(frac) * n) >> 16);
    return (s > n - 1) ? n - 1 : s;
  endfunction

  function automatic bin_result_t predict_bin_result(probe_t p);
    bin_result_t r;
    int nxy, naz, d, a, g, idx, lim, c;
    longint n2;
    nxy = (xy_dirs_q == 0) ? 1 : (xy_dirs_q > NXY_MAX ? NXY_MAX : xy_dirs_q);
    naz = (az_divs_q == 0) ? 1 : (az_divs_q > NAZ_MAX ? NAZ_MAX : az_divs_q);
    d = (p.dz > cutoff_q) ? 0 : sector(turn_frac(p.dx, p.dy), nxy) + 1;
    a = sector(turn_frac(p.px, p.py), naz);
    n2 = longint'(p.px) * p.px + longint'(p.py) * p.py + longint'(p.pz) * p.pz;
    g = 0;
    for (int i = 0; i < 3; i++)
      if (longint'(rthr_q[i]) * rthr_q[i] <= n2) g++;
    idx = (d * NAZ_MAX + a) * NRB + g;
    lim = (d == 0) ? zlim_q : xylim_q;
    c = bin_store[idx];
    r.ok = 1'b1;
    case (p.cmd)
      CMD_INSERT: begin
        if (c < lim) c++;
        else r.ok = 1'b0;
        bin_store[idx] = 8'(c);
      end
      CMD_QUERY: r.ok = (c < lim);
      CMD_REMOVE: begin
        if (c > 0) c--;
        bin_store[idx] = 8'(c);
      end
      default: begin
        foreach (bin_store[k]) bin_store[k] = '0;
        c = 0;
      end
    endcase
    r.count = 8'(c);
    r.dir = 4'(d);
    r.az = 4'(a);
    r.rng = 2'(g);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Driver: one beat in flight, next beat taken from the pending queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        probe_t p;
        p = pending_beats.pop_front();
        in_cmd <= p.cmd;
        in_dir_x <= p.dx;
        in_dir_y <= p.dy;
        in_dir_z <= p.dz;
        in_pt_x <= p.px;
        in_pt_y <= p.py;
        in_pt_z <= p.pz;
        in_valid <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each accepted input beat, checks each result beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_bins.push_back(predict_bin_result(
          '{in_cmd, in_dir_x, in_dir_y, in_dir_z, in_pt_x, in_pt_y, in_pt_z}));
      if (out_valid && out_ready) begin
        if (expected_bins.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          bin_result_t e;
          e = expected_bins.pop_front();
          if (out_ok !== e.ok) report_mismatch("ok", out_ok, e.ok);
          if (out_count !== e.count) report_mismatch("count", out_count, e.count);
          if (out_dir_index !== e.dir) report_mismatch("dir_index", out_dir_index, e.dir);
          if (out_azimuth_index !== e.az)
            report_mismatch("azimuth_index", out_azimuth_index, e.az);
          if (out_range_index !== e.rng)
            report_mismatch("range_index", out_range_index, e.rng);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        stall_left <= pick_gap();
        out_ready <= 1'b1;
      end
    end
  end

  task automatic drain();
    wait (pending_beats.size() == 0);
    @(posedge clk);
    while (in_valid || expected_bins.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [19:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= 3'(idx);
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_Z_CUTOFF: cutoff_q = v[15:0];
      REG_XY_DIRS:  xy_dirs_q = v[3:0];
      REG_AZ_DIVS:  az_divs_q = v[4:0];
      REG_Z_LIMIT:  zlim_q = v[7:0];
      REG_XY_LIMIT: xylim_q = v[7:0];
      default:      rthr_q[idx - REG_RANGE_DIV] = v;
    endcase
    foreach (bin_store[k]) bin_store[k] = '0;
    repeat (3) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic setup(logic signed [15:0] zc, int nx, int na, int zl, int xl,
                       int t0, int t1, int t2);
    drain();
    write_reg(REG_Z_CUTOFF, {{4{zc[15]}}, zc});
    write_reg(REG_XY_DIRS, 20'(nx));
    write_reg(REG_AZ_DIVS, 20'(na));
    write_reg(REG_Z_LIMIT, 20'(zl));
    write_reg(REG_XY_LIMIT, 20'(xl));
    write_reg(REG_RANGE_DIV, 20'(t0));
    write_reg(REG_RANGE_DIV + 1, 20'(t1));
    write_reg(REG_RANGE_DIV + 2, 20'(t2));
  endtask

  function automatic logic signed [15:0] rand_dir();
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic probe_t rand_probe();
    probe_t p;
    p.cmd = 2'($urandom_range(0, 3));
    p.dx = rand_dir();
    p.dy = rand_dir();
    p.dz = rand_dir();
    p.px = 20'($urandom);
    p.py = 20'($urandom);
    p.pz = 20'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      p.px = p.px >>> $urandom_range(4, 12);
      p.py = p.py >>> $urandom_range(4, 12);
      p.pz = p.pz >>> $urandom_range(4, 12);
    end
    return p;
  endfunction

  task automatic random_phase(int n);
    probe_t p;
    int r;
    for (int i = 0; i < 8; i++) pool[i] = rand_probe();
    for (int i = 0; i < n; i++) begin
      calm = ((i / 50) % 4 == 3);
      p = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : rand_probe();
      r = $urandom_range(0, 99);
      p.cmd = (r < 55) ? CMD_INSERT : (r < 75) ? CMD_QUERY : (r < 98) ? CMD_REMOVE
            : CMD_CLEAR;
      pending_beats.push_back(p);
      if (pending_beats.size() > 4) wait (pending_beats.size() <= 4);
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    fail_count = 0;
    calm = 1'b0;
    foreach (bin_store[k]) bin_store[k] = '0;
    cutoff_q = RST_Z_CUTOFF;
    xy_dirs_q = RST_XY_DIRS;
    az_divs_q = RST_AZ_DIVS;
    zlim_q = RST_LIMIT;
    xylim_q = RST_LIMIT;
    foreach (rthr_q[k]) rthr_q[k] = THR_UNUSED;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats at reset settings: zero vectors, axis extremes, every command.
    pending_beats.push_back('{CMD_INSERT, 16'sd0, 16'sd0, 16'sd0, 20'sd0, 20'sd0, 20'sd0});
    pending_beats.push_back('{CMD_INSERT, 16'sd0, 16'sd0, 16'sd0, 20'sd0, 20'sd0, 20'sd0});
    pending_beats.push_back('{CMD_QUERY, 16'sd0, 16'sd0, 16'sd0, 20'sd0, 20'sd0, 20'sd0});
    pending_beats.push_back('{CMD_REMOVE, 16'sd0, 16'sd0, 16'sd0, 20'sd0, 20'sd0, 20'sd0});
    pending_beats.push_back('{CMD_INSERT, -16'sd16384, 16'sd0, 16'sd14189,
                              -20'sd524288, 20'sd0, 20'sd524287});
    pending_beats.push_back('{CMD_INSERT, -16'sd16384, -16'sd1, 16'sd14190,
                              -20'sd524288, -20'sd1, -20'sd524288});
    pending_beats.push_back('{CMD_INSERT, 16'sd16384, 16'sd16384, -16'sd16384,
                              20'sd524287, 20'sd524287, 20'sd524287});
    pending_beats.push_back('{CMD_QUERY, 16'sd0, -16'sd16384, 16'sd16384,
                              20'sd0, -20'sd524288, 20'sd0});
    pending_beats.push_back('{CMD_CLEAR, 16'sd5, -16'sd7, 16'sd0, 20'sd9, 20'sd3, 20'sd1});
    pending_beats.push_back('{CMD_REMOVE, 16'sd5, -16'sd7, 16'sd0, 20'sd9, 20'sd3, 20'sd1});
    for (int i = 0; i < 12; i++)
      pending_beats.push_back('{CMD_INSERT, 16'sd100, 16'sd200, 16'sd0,
                                20'sd1000, 20'sd10, 20'sd0});
    pending_beats.push_back('{CMD_QUERY, 16'sd100, 16'sd200, 16'sd0,
                              20'sd1000, 20'sd10, 20'sd0});

    // Extreme settings: zero thresholds, out-of-range sector counts, zero and max caps.
    setup(-16'sd16384, 15, 31, 0, 255, 0, 20'hFFFFF, 256);
    pending_beats.push_back('{CMD_INSERT, 16'sd0, 16'sd0, 16'sd0, 20'sd0, 20'sd0, 20'sd0});
    pending_beats.push_back('{CMD_INSERT, 16'sd0, 16'sd0, -16'sd16384,
                              20'sd256, 20'sd0, 20'sd0});
    pending_beats.push_back('{CMD_INSERT, 16'sd0, 16'sd0, 16'sd16384,
                              -20'sd255, 20'sd0, 20'sd0});
    setup(16'sd16384, 0, 0, 255, 0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    pending_beats.push_back('{CMD_INSERT, -16'sd3, 16'sd9, 16'sd16384,
                              20'sd77, -20'sd5, 20'sd1});
    pending_beats.push_back('{CMD_QUERY, -16'sd3, 16'sd9, 16'sd16384,
                              20'sd77, -20'sd5, 20'sd1});

    random_phase(300);
    setup(RST_Z_CUTOFF, 8, 16, 3, 5, 5000, 60000, 300000);
    random_phase(300);
    setup(16'sd0, 1, 1, 1, 2, 400000, 20000, 0);
    random_phase(300);
    for (int ph = 0; ph < 3; ph++) begin
      setup(rand_dir(), $urandom_range(0, 15), $urandom_range(0, 31),
            $urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 600000),
            $urandom_range(0, 600000), $urandom_range(0, 1048575));
      random_phase(300);
    end

    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
